### sv/fltc_pkg.sv
package fltc_pkg;

  localparam int WORD_W    = 32;
  localparam int KIND_W    = 3;
  localparam int LINE_W    = 10;
  localparam int COL_W     = 9;
  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 1;
  localparam int MODE_W    = 2;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_LINE_WORDS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT = 1'd1;

  // input word kinds
  localparam logic [KIND_W-1:0] KIND_START  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_WORD   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SKIP   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_END    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RESIZE = 3'd4;
  localparam logic [KIND_W-1:0] KIND_HALT   = 3'd5;

  // per-line modes
  localparam logic [MODE_W-1:0] MODE_IDLE    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_COMPARE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COPY    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_FINISH  = 2'd3;

  typedef struct packed {
    logic              accepted;
    logic              begin_request;
    logic              flush;
    logic [LINE_W-1:0] first_changed_line;
    logic [LINE_W-1:0] end_changed_line;
    logic [COL_W-1:0]  first_changed_column;
  } result_t;

endpackage

### sv/frame_line_change_tracker_core.sv
// Frame line change tracker: keeps the last frame in an on-chip word store
// and compares incoming scanline words with it, reporting the changed
// region (first line, end line, leftmost word column) of the open update.
// Input channel: in_valid/in_ready with kind, pixel_word, host_ready.
// Output channel: out_valid/out_ready, one result word per input word.
// Config port: cfg_write with cfg_index (0 line_words, 1 line_count) and
// cfg_data; write only while no word is in flight.
// Throughput: one word per cycle while the output is not stalled. The
// store is read the cycle a word is accepted and written when that word
// leaves the compare stage; the read address comes from the tracker's
// next state, so a word can follow in every cycle. The compare stage
// is loaded as a word is accepted; its result is registered as it leaves.
// Stall: while out_ready is low the output holds, the word in the compare
// stage waits, and in_ready drops once that stage is full.
// Reset (rst, synchronous): clears control state and config registers; the
// store is not cleared, its entries are defined once written.
module frame_line_change_tracker_core import fltc_pkg::*; #(
  parameter int MAX_LINE_WORDS = 256,
  parameter int MAX_LINES      = 512
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [KIND_W-1:0]    kind,
  input  logic [WORD_W-1:0]    pixel_word,
  input  logic                 host_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 accepted,
  output logic                 begin_request,
  output logic                 flush,
  output logic [LINE_W-1:0]    first_changed_line,
  output logic [LINE_W-1:0]    end_changed_line,
  output logic [COL_W-1:0]     first_changed_column
);

  localparam int DEPTH  = MAX_LINE_WORDS * MAX_LINES;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic              in_fire;
  logic              ex_valid;
  logic              ex_adv;
  logic [KIND_W-1:0] ex_kind;
  logic [WORD_W-1:0] ex_word;
  logic              ex_host_ready;

  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [WORD_W-1:0] rd_data;
  logic [WORD_W-1:0] wr_data;
  logic              wr_en;
  result_t           res;
  result_t           out_res;

  assign ex_adv   = ex_valid && (!out_valid || out_ready);
  assign in_ready = !ex_valid || ex_adv;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid <= 1'b0;
    end else if (in_ready) begin
      ex_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ex_kind       <= kind;
      ex_word       <= pixel_word;
      ex_host_ready <= host_ready;
    end
  end

  fltc_frame_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .rd_en   (in_fire && kind == KIND_WORD),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  fltc_tracker #(
    .MAX_LINE_WORDS (MAX_LINE_WORDS),
    .MAX_LINES      (MAX_LINES)
  ) u_tracker (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .ex_adv        (ex_adv),
    .ex_kind       (ex_kind),
    .ex_word       (ex_word),
    .ex_host_ready (ex_host_ready),
    .rd_data       (rd_data),
    .rd_addr       (rd_addr),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ex_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_adv) begin
      out_res <= res;
    end
  end

  assign accepted             = out_res.accepted;
  assign begin_request        = out_res.begin_request;
  assign flush                = out_res.flush;
  assign first_changed_line   = out_res.first_changed_line;
  assign end_changed_line     = out_res.end_changed_line;
  assign first_changed_column = out_res.first_changed_column;

  a_fire_loads_stage: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> ex_valid)
    else $error("accepted word did not reach compare stage");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (ex_valid && !ex_adv) |=> (ex_valid && $stable(ex_kind) && $stable(ex_word)))
    else $error("stalled compare stage lost its word");

  a_adv_fills_out: assert property (@(posedge clk) disable iff (rst)
    ex_adv |=> out_valid)
    else $error("result not presented after compare stage advanced");

endmodule

### sv/fltc_frame_ram.sv
module fltc_frame_ram import fltc_pkg::*; #(
  parameter int DEPTH = 131072
) (
  input  logic                                    clk,
  input  logic                                    rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WORD_W-1:0]                       rd_data,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WORD_W-1:0]                       wr_data
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] mem_q;
  logic [WORD_W-1:0] fwd_data;
  logic              fwd_hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read and write to the same entry in one cycle: pass the new word along
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q    <= mem[rd_addr];
      fwd_hit  <= wr_en && (wr_addr == rd_addr);
      fwd_data <= wr_data;
    end
  end

  assign rd_data = fwd_hit ? fwd_data : mem_q;

endmodule

### sv/fltc_tracker.sv
module fltc_tracker import fltc_pkg::*; #(
  parameter int MAX_LINE_WORDS = 256,
  parameter int MAX_LINES      = 512
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 ex_adv,
  input  logic [KIND_W-1:0]    ex_kind,
  input  logic [WORD_W-1:0]    ex_word,
  input  logic                 ex_host_ready,
  input  logic [WORD_W-1:0]    rd_data,
  output logic [((MAX_LINE_WORDS * MAX_LINES > 1) ?
                 $clog2(MAX_LINE_WORDS * MAX_LINES) : 1)-1:0] rd_addr,
  output logic                 wr_en,
  output logic [((MAX_LINE_WORDS * MAX_LINES > 1) ?
                 $clog2(MAX_LINE_WORDS * MAX_LINES) : 1)-1:0] wr_addr,
  output logic [WORD_W-1:0]    wr_data,
  output result_t              res
);

  localparam int DEPTH  = MAX_LINE_WORDS * MAX_LINES;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [COL_W-1:0]  line_words;
  logic [LINE_W-1:0] line_count;

  logic [MODE_W-1:0] mode, mode_next;
  logic              updating, updating_next;
  logic              active, active_next;
  logic              full_rw, full_rw_next;
  logic              rw_pend, rw_pend_next;
  logic [LINE_W-1:0] store_line, store_line_next;
  logic [COL_W-1:0]  wpos, wpos_next;
  logic [LINE_W-1:0] cur_line, cur_line_next;
  logic [LINE_W-1:0] top, top_next;
  logic [LINE_W-1:0] bot, bot_next;
  logic [COL_W-1:0]  left, left_next;
  logic              differs, differs_next;

  logic              geo_ok;
  logic              in_range;
  logic              do_copy;
  logic              do_adv;
  logic              do_nl;
  logic              cnt_line;
  logic              word_eq;
  logic [COL_W:0]    wpos_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_words <= '0;
      line_count <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LINE_WORDS: line_words <= cfg_data[COL_W-1:0];
        REG_LINE_COUNT: line_count <= cfg_data[LINE_W-1:0];
        default: ;
      endcase
    end
  end

  assign geo_ok = (line_words != '0) && (32'(line_words) <= 32'(MAX_LINE_WORDS)) &&
                  (line_count != '0) && (32'(line_count) <= 32'(MAX_LINES));
  assign in_range = geo_ok && (store_line < line_count);
  assign word_eq  = (rd_data == ex_word);
  assign wpos_inc = {1'b0, wpos} + 1'b1;

  always_comb begin
    mode_next       = mode;
    updating_next   = updating;
    active_next     = active;
    full_rw_next    = full_rw;
    rw_pend_next    = rw_pend;
    store_line_next = store_line;
    wpos_next       = wpos;
    cur_line_next   = cur_line;
    top_next        = top;
    bot_next        = bot;
    left_next       = left;
    differs_next    = differs;
    res.accepted      = 1'b0;
    res.begin_request = 1'b0;
    res.flush         = 1'b0;
    do_copy  = 1'b0;
    do_adv   = 1'b0;
    do_nl    = 1'b0;
    cnt_line = 1'b0;

    if (ex_adv) begin
      case (ex_kind)
        KIND_START: begin
          if (!updating && active) begin
            store_line_next = '0;
            wpos_next       = '0;
            differs_next    = 1'b0;
            left_next       = line_words;
            top_next        = '0;
            bot_next        = '0;
            cur_line_next   = '0;
            if (rw_pend) begin
              rw_pend_next      = 1'b0;
              full_rw_next      = 1'b1;
              res.begin_request = 1'b1;
              if (ex_host_ready) begin
                mode_next     = MODE_COPY;
                updating_next = 1'b1;
                res.accepted  = 1'b1;
              end
            end else begin
              mode_next     = MODE_COMPARE;
              updating_next = 1'b1;
              res.accepted  = 1'b1;
            end
          end
        end
        KIND_WORD: begin
          if (mode != MODE_IDLE && in_range) begin
            case (mode)
              MODE_FINISH: begin
                do_adv = 1'b1;
              end
              MODE_COPY: begin
                do_copy = 1'b1;
              end
              default: begin
                if (word_eq) begin
                  do_adv   = 1'b1;
                  cnt_line = 1'b1;
                end else begin
                  res.begin_request = 1'b1;
                  if (!ex_host_ready) begin
                    mode_next = MODE_IDLE;
                  end else begin
                    top_next  = cur_line;
                    bot_next  = cur_line;
                    mode_next = MODE_COPY;
                    do_copy   = 1'b1;
                  end
                end
              end
            endcase
          end
        end
        KIND_SKIP: begin
          if (mode != MODE_IDLE && in_range) begin
            do_nl    = 1'b1;
            cnt_line = (mode != MODE_FINISH);
          end
        end
        KIND_END: begin
          if (updating) begin
            mode_next     = MODE_IDLE;
            res.flush     = (top != bot);
            full_rw_next  = 1'b0;
            updating_next = 1'b0;
          end
        end
        KIND_RESIZE: begin
          mode_next     = MODE_IDLE;
          updating_next = 1'b0;
          active_next   = 1'b0;
          res.flush     = 1'b1;
          if (geo_ok) begin
            mode_next    = MODE_FINISH;
            rw_pend_next = 1'b1;
            active_next  = 1'b1;
          end
        end
        KIND_HALT: begin
          mode_next     = MODE_IDLE;
          updating_next = 1'b0;
          active_next   = 1'b0;
          res.flush     = 1'b1;
        end
        default: ;
      endcase
    end

    // copy-changed: first written word of a line (differing, or any on a full rewrite) takes that line into the region
    wr_en = 1'b0;
    if (do_copy) begin
      do_adv   = 1'b1;
      cnt_line = 1'b1;
      if (full_rw || differs || !word_eq) begin
        wr_en = 1'b1;
        if (!differs) begin
          differs_next = 1'b1;
          bot_next     = cur_line + 1'b1;
          if (full_rw) begin
            left_next = '0;
          end else if (wpos < left) begin
            left_next = wpos;
          end
        end
      end
    end
    if (ex_adv && ex_kind == KIND_WORD && mode == MODE_FINISH && in_range) begin
      wr_en = 1'b1;
    end

    if (do_adv) begin
      if (wpos_inc >= {1'b0, line_words}) begin
        do_nl = 1'b1;
      end else begin
        wpos_next = wpos_inc[COL_W-1:0];
      end
    end
    if (do_nl) begin
      wpos_next       = '0;
      differs_next    = 1'b0;
      store_line_next = store_line + 1'b1;
      if (cnt_line) begin
        cur_line_next = cur_line + 1'b1;
      end
    end

    res.first_changed_line   = top_next;
    res.end_changed_line     = bot_next;
    res.first_changed_column = left_next;
  end

  assign wr_addr = ADDR_W'(32'(store_line) * 32'(MAX_LINE_WORDS) + 32'(wpos));
  assign rd_addr = ADDR_W'(32'(store_line_next) * 32'(MAX_LINE_WORDS) + 32'(wpos_next));
  assign wr_data = ex_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      updating   <= 1'b1;
      active     <= 1'b0;
      full_rw    <= 1'b0;
      rw_pend    <= 1'b0;
      store_line <= '0;
      wpos       <= '0;
      cur_line   <= '0;
      top        <= '0;
      bot        <= '0;
      left       <= '0;
      differs    <= 1'b0;
    end else begin
      mode       <= mode_next;
      updating   <= updating_next;
      active     <= active_next;
      full_rw    <= full_rw_next;
      rw_pend    <= rw_pend_next;
      store_line <= store_line_next;
      wpos       <= wpos_next;
      cur_line   <= cur_line_next;
      top        <= top_next;
      bot        <= bot_next;
      left       <= left_next;
      differs    <= differs_next;
    end
  end

  a_scan_needs_update: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_COMPARE || mode == MODE_COPY) |-> updating)
    else $error("compare/copy mode outside an open update");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (ex_adv && store_line < line_count))
    else $error("store write outside configured lines");

  a_line_order: assert property (@(posedge clk) disable iff (rst)
    cur_line <= store_line)
    else $error("current line ahead of store line");

endmodule
